/* hw/rtl/ffba_pkg.sv */
// Shared types and codes of the first-fit block allocator.
package ffba_pkg;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusAllocErr = 2'd1;
  localparam logic [1:0] StatusFreeErr  = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [10:0] {
    StIdle    = 11'b00000000001,
    StARd     = 11'b00000000010,
    StAChk    = 11'b00000000100,
    StASplit  = 11'b00000001000,
    StALink   = 11'b00000010000,
    StFRd     = 11'b00000100000,
    StFWalk   = 11'b00001000000,
    StFNext   = 11'b00010000000,
    StFPrevRd = 11'b00100000000,
    StFPrev   = 11'b01000000000,
    StDone    = 11'b10000000000
  } state_e;

endpackage

/* hw/rtl/first_fit_block_allocator.sv */
// First-fit block allocator: sorted free list with coalescing, headers in RAM.
// A zero-size allocate or a rejected free goes from idle straight to the done state.
// One request at a time: busy is high from start until done_o, the next start is taken the
// cycle after done_o; the receiver cannot stall. Reset: one free region spans the heap.
module first_fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [11:0] req_blocks_i,
  input  logic [12:0] user_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [12:0] granted_index_o
);

  localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned IW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = IW + 1;
  localparam logic [IW-1:0] Nil = IW'(NUM_BLOCKS);

  // Each header word is {length, link}; one RAM, one write port and one read port.
  logic [LW+IW-1:0] mem_q [NUM_BLOCKS];
  logic [LW+IW-1:0] rdata_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [LW+IW-1:0] wdata;
  // Header 0 is initialized by a valid flag rather than a clearing pass.
  logic             h0_valid_q;

  ffba_pkg::state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d, cur_q, cur_d, prev_q, prev_d, node_q, node_d;
  logic [LW-1:0] need_q, need_d, plen_q, plen_d, nlen_q, nlen_d;
  logic [IW-1:0] nlink_q, nlink_d;
  logic [IW:0]   steps_q, steps_d;
  logic [1:0]    status_q, status_d;
  logic [12:0]   grant_q, grant_d;
  logic          rd_en;
  logic [AW-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (we && waddr == '0) h0_valid_q <= 1'b1;
      if (rd_en) rd_addr_q <= raddr;
    end
  end

  logic [LW-1:0] r_len;
  logic [IW-1:0] r_link;
  assign r_len  = (rd_addr_q == '0 && !h0_valid_q) ? LW'(NUM_BLOCKS) : rdata_q[LW+IW-1:IW];
  assign r_link = (rd_addr_q == '0 && !h0_valid_q) ? Nil : rdata_q[IW-1:0];

  function automatic logic is_node(logic [IW-1:0] i);
    return i < IW'(NUM_BLOCKS);
  endfunction

  logic [IW:0] fidx;
  assign fidx = (IW+1)'(user_index_i) - (IW+1)'(1);
  logic [LW:0] sum_nc, sum_pn;
  assign sum_nc = (LW+1)'(node_q) + (LW+1)'(nlen_q);
  assign sum_pn = (LW+1)'(prev_q) + (LW+1)'(plen_q);

  assign busy = (state_q != ffba_pkg::StIdle);

  always_comb begin
    state_d = state_q; head_d = head_q; cur_d = cur_q; prev_d = prev_q;
    node_d = node_q; need_d = need_q; plen_d = plen_q; nlen_d = nlen_q;
    nlink_d = nlink_q; steps_d = steps_q; status_d = status_q; grant_d = grant_q;
    we = 1'b0; waddr = '0; wdata = '0; rd_en = 1'b0; raddr = '0;
    unique case (state_q)
      ffba_pkg::StIdle: begin
        if (start) begin
          grant_d = '0; status_d = ffba_pkg::StatusOk;
          prev_d = Nil; cur_d = head_q; steps_d = '0;
          if (opcode_i == ffba_pkg::OpAlloc) begin
            need_d = LW'(req_blocks_i) + LW'(1);
            if (req_blocks_i == '0) begin
              status_d = ffba_pkg::StatusAllocErr; state_d = ffba_pkg::StDone;
            end else state_d = ffba_pkg::StARd;
          end else begin
            node_d = fidx[IW-1:0];
            if (user_index_i == '0 || fidx >= (IW+1)'(NUM_BLOCKS)) begin
              status_d = ffba_pkg::StatusFreeErr; state_d = ffba_pkg::StDone;
            end else state_d = ffba_pkg::StFRd;
          end
        end
      end
      ffba_pkg::StARd: begin
        if (!is_node(cur_q) || steps_q >= (IW+1)'(NUM_BLOCKS)) begin
          status_d = ffba_pkg::StatusAllocErr; state_d = ffba_pkg::StDone;
        end else begin
          rd_en = 1'b1; raddr = cur_q[AW-1:0]; state_d = ffba_pkg::StAChk;
        end
      end
      ffba_pkg::StAChk: begin
        if (r_len >= need_q) begin
          nlen_d = r_len; nlink_d = r_link; state_d = ffba_pkg::StASplit;
        end else begin
          prev_d = cur_q; cur_d = r_link; steps_d = steps_q + 1'b1;
          state_d = ffba_pkg::StARd;
        end
      end
      ffba_pkg::StASplit: begin
        // If a remainder is left, write its header; nlink becomes successor of cur.
        if (nlen_q != need_q) begin
          we = 1'b1; waddr = AW'(cur_q + IW'(need_q));
          wdata = {nlen_q - need_q, nlink_q};
          nlink_d = IW'(cur_q + IW'(need_q));
        end
        state_d = ffba_pkg::StALink;
      end
      ffba_pkg::StALink: begin
        // Write cur header now; if prev exists, its link is written in StFPrev, else head moves.
        we = 1'b1; waddr = cur_q[AW-1:0]; wdata = {need_q, Nil};
        if (is_node(prev_q)) begin
          // prev's length is plen_q, captured on the walk.
          cur_d = nlink_q; state_d = ffba_pkg::StFPrev; node_d = Nil;
        end else begin
          head_d = nlink_q; state_d = ffba_pkg::StDone;
        end
        grant_d = 13'(cur_q + IW'(1));
      end
      ffba_pkg::StFRd: begin
        if (!is_node(cur_q) || cur_q >= node_q || steps_q >= (IW+1)'(NUM_BLOCKS)) begin
          if (is_node(cur_q) && cur_q < node_q) cur_d = Nil;
          rd_en = 1'b1; raddr = node_q[AW-1:0]; state_d = ffba_pkg::StFWalk;
        end else begin
          rd_en = 1'b1; raddr = cur_q[AW-1:0]; state_d = ffba_pkg::StFWalk;
          steps_d = steps_q + 1'b1; node_d = node_q;
          prev_d = cur_q; cur_d = Nil; nlink_d = cur_q;
        end
      end
      ffba_pkg::StFWalk: begin
        // walk reads always hit a header below node, so the address tells them apart
        if (rd_addr_q == node_q[AW-1:0]) begin
          // node header read done: node's own length
          nlen_d = r_len; rd_en = is_node(cur_q); raddr = cur_q[AW-1:0];
          state_d = ffba_pkg::StFNext;
        end else begin
          plen_d = r_len; cur_d = r_link; nlink_d = Nil;
          state_d = ffba_pkg::StFRd;
        end
      end
      ffba_pkg::StFNext: begin
        // merge node with cur if adjacent
        if (is_node(cur_q) && sum_nc == (LW+1)'(cur_q)) begin
          nlen_d = nlen_q + r_len; nlink_d = r_link;
        end else nlink_d = cur_q;
        state_d = ffba_pkg::StFPrevRd;
      end
      ffba_pkg::StFPrevRd: begin
        if (is_node(prev_q) && sum_pn == (LW+1)'(node_q)) begin
          we = 1'b1; waddr = prev_q[AW-1:0]; wdata = {plen_q + nlen_q, nlink_q};
          state_d = ffba_pkg::StDone;
        end else begin
          we = 1'b1; waddr = node_q[AW-1:0]; wdata = {nlen_q, nlink_q};
          if (is_node(prev_q)) begin
            cur_d = node_q; state_d = ffba_pkg::StFPrev;
          end else begin
            head_d = node_q; state_d = ffba_pkg::StDone;
          end
        end
      end
      ffba_pkg::StFPrev: begin
        we = 1'b1; waddr = prev_q[AW-1:0]; wdata = {plen_q, cur_q};
        state_d = ffba_pkg::StDone;
      end
      ffba_pkg::StDone: state_d = ffba_pkg::StIdle;
      default: state_d = ffba_pkg::StIdle;
    endcase
    // keep prev length while walking for alloc unlink
    if (state_q == ffba_pkg::StAChk && r_len < need_q) plen_d = r_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::StIdle; head_q <= '0;
    end else begin
      state_q <= state_d; head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; prev_q <= prev_d; node_q <= node_d; need_q <= need_d;
    plen_q <= plen_d; nlen_q <= nlen_d; nlink_q <= nlink_d; steps_q <= steps_d;
    status_q <= status_d; grant_q <= grant_d;
  end

  assign done_o = (state_q == ffba_pkg::StDone);
  assign status_o = status_q;
  assign granted_index_o = grant_q;

endmodule
